// ===== sv/cdds_pkg.sv =====
// Package for the calendar date day stepper: widths, default date, item types,
// sequencer states and the constants of the divisibility-by-25 leap test.
// No dependencies; every other file of the block uses it by scoped names.
package cdds_pkg;

  localparam int YEAR_BITS  = 14;
  localparam int DELTA_BITS = 16;
  localparam int DAY_BITS   = 5;
  localparam int MONTH_BITS = 4;

  localparam logic [YEAR_BITS-1:0]  YEAR_TOP             = '1;
  localparam logic [YEAR_BITS-1:0]  YEAR_FIRST           = '0;
  localparam logic [YEAR_BITS-1:0]  DEFAULT_YEAR         = YEAR_BITS'(2023);
  localparam logic [YEAR_BITS-1:0]  MAX_SET_YEAR_RESET   = YEAR_BITS'(2029);
  localparam logic [DAY_BITS-1:0]   FIRST_DAY            = DAY_BITS'(1);
  localparam logic [DAY_BITS-1:0]   LAST_DAY_OF_DECEMBER = DAY_BITS'(31);
  localparam logic [MONTH_BITS-1:0] JANUARY              = MONTH_BITS'(1);
  localparam logic [MONTH_BITS-1:0] DECEMBER             = MONTH_BITS'(12);

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_SHIFT = 1'b1;

  // Inverse of an odd number modulo 2^32 by Newton iteration; each pass
  // doubles the number of correct low bits, starting from three.
  function automatic logic [31:0] inv_odd(input logic [31:0] d);
    logic [31:0] x;
    x = d;
    for (int i = 0; i < 4; i++) begin
      x = x * (32'd2 - d * x);
    end
    return x;
  endfunction

  // A year is a multiple of 25 exactly when year * INV25 (modulo 2^YEAR_BITS)
  // does not exceed DIV25_LIMIT.
  localparam logic [YEAR_BITS-1:0] INV25       = YEAR_BITS'(inv_odd(32'd25));
  localparam logic [YEAR_BITS-1:0] DIV25_LIMIT = YEAR_BITS'((2**YEAR_BITS - 1) / 25);

  typedef struct packed {
    logic                         command;
    logic [DAY_BITS-1:0]          set_day;
    logic [MONTH_BITS-1:0]        set_month;
    logic [YEAR_BITS-1:0]         set_year;
    logic signed [DELTA_BITS-1:0] day_delta;
  } in_item_t;

  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
    logic                  leap_year;
    logic                  set_rejected;
    logic                  range_saturated;
  } out_item_t;

  typedef struct packed {
    logic [DAY_BITS-1:0]   day;
    logic [MONTH_BITS-1:0] month;
    logic [YEAR_BITS-1:0]  year;
  } date_t;

  typedef struct packed {
    date_t               next;
    logic                blocked;
    logic                leap;
    logic [DAY_BITS-1:0] mlen;
  } step_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP,
    ST_FINISH
  } state_t;

endpackage

// ===== sv/cdds_step_unit.sv =====
// Shared day step unit: leap test, month length and the date one day on or back.
// Depends on cdds_pkg.
module cdds_step_unit (
  input  cdds_pkg::date_t     date,
  input  logic                back,
  output cdds_pkg::step_rsp_t rsp
);

  logic [cdds_pkg::YEAR_BITS-1:0]    prod;
  logic                              div25;
  logic                              leap;
  logic [cdds_pkg::MONTH_BITS-1:0]   prev_month;

  function automatic logic [cdds_pkg::DAY_BITS-1:0] month_len(
    input logic [cdds_pkg::MONTH_BITS-1:0] m,
    input logic                            lp
  );
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      4'd2:                    month_len = lp ? 5'd29 : 5'd28;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  // Only the low YEAR_BITS of the product matter for the divisibility test.
  assign prod  = date.year * cdds_pkg::INV25;
  assign div25 = (prod <= cdds_pkg::DIV25_LIMIT);
  // Multiple of 4 but not of 100, or multiple of 400 (16 and 25).
  assign leap  = ((date.year[1:0] == 2'b00) && !div25) ||
                 ((date.year[3:0] == 4'b0000) && div25);
  assign prev_month = date.month - cdds_pkg::MONTH_BITS'(1);

  always_comb begin
    rsp.leap    = leap;
    rsp.mlen    = month_len(date.month, leap);
    rsp.blocked = 1'b0;
    rsp.next    = date;
    if (!back) begin
      if (date.day < rsp.mlen) begin
        rsp.next.day = date.day + cdds_pkg::DAY_BITS'(1);
      end else if (date.month < cdds_pkg::DECEMBER) begin
        rsp.next.day   = cdds_pkg::FIRST_DAY;
        rsp.next.month = date.month + cdds_pkg::MONTH_BITS'(1);
      end else if (date.year == cdds_pkg::YEAR_TOP) begin
        rsp.blocked = 1'b1;
      end else begin
        rsp.next.day   = cdds_pkg::FIRST_DAY;
        rsp.next.month = cdds_pkg::JANUARY;
        rsp.next.year  = date.year + cdds_pkg::YEAR_BITS'(1);
      end
    end else begin
      if (date.day > cdds_pkg::FIRST_DAY) begin
        rsp.next.day = date.day - cdds_pkg::DAY_BITS'(1);
      end else if (date.month > cdds_pkg::JANUARY) begin
        rsp.next.month = prev_month;
        rsp.next.day   = month_len(prev_month, leap);
      end else if (date.year == cdds_pkg::YEAR_FIRST) begin
        rsp.blocked = 1'b1;
      end else begin
        rsp.next.day   = cdds_pkg::LAST_DAY_OF_DECEMBER;
        rsp.next.month = cdds_pkg::DECEMBER;
        rsp.next.year  = date.year - cdds_pkg::YEAR_BITS'(1);
      end
    end
  end

endmodule

// ===== sv/cdds_ctrl.sv =====
// Sequencer of the date stepper: date and countdown registers, set check,
// one day step per cycle through the shared unit, and the result register.
// Depends on cdds_pkg; drives cdds_step_unit from the top level.
module cdds_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  cdds_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output cdds_pkg::out_item_t              out_data,
  input  logic [cdds_pkg::YEAR_BITS-1:0]   max_set_year,
  output cdds_pkg::date_t                  unit_date,
  output logic                             unit_back,
  input  cdds_pkg::step_rsp_t              unit_rsp
);

  cdds_pkg::state_t                  state, state_next;
  cdds_pkg::date_t                   cur, cur_next;
  cdds_pkg::date_t                   set_date, set_date_next;
  logic [cdds_pkg::DELTA_BITS-1:0]   days_left, days_left_next;
  logic                              back, back_next;
  logic                              rejected, rejected_next;
  logic                              saturated, saturated_next;
  logic                              out_valid_next;
  cdds_pkg::out_item_t               out_data_next;
  logic [cdds_pkg::DELTA_BITS-1:0]   delta_raw;
  logic [cdds_pkg::DELTA_BITS-1:0]   delta_mag;
  logic                              set_ok;

  assign in_stall  = (state != cdds_pkg::ST_IDLE);
  assign unit_date = (state == cdds_pkg::ST_CHECK) ? set_date : cur;
  assign unit_back = back;

  assign delta_raw = in_data.day_delta;
  assign delta_mag = delta_raw[cdds_pkg::DELTA_BITS-1] ?
                     (~delta_raw + cdds_pkg::DELTA_BITS'(1)) : delta_raw;

  assign set_ok = (set_date.month >= cdds_pkg::JANUARY) &&
                  (set_date.month <= cdds_pkg::DECEMBER) &&
                  (set_date.year != cdds_pkg::YEAR_FIRST) &&
                  (set_date.year <= max_set_year) &&
                  (set_date.day >= cdds_pkg::FIRST_DAY) &&
                  (set_date.day <= unit_rsp.mlen);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    set_date_next  = set_date;
    days_left_next = days_left;
    back_next      = back;
    rejected_next  = rejected;
    saturated_next = saturated;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    case (state)
      cdds_pkg::ST_IDLE: begin
        if (in_valid) begin
          set_date_next.day   = in_data.set_day;
          set_date_next.month = in_data.set_month;
          set_date_next.year  = in_data.set_year;
          back_next           = delta_raw[cdds_pkg::DELTA_BITS-1];
          rejected_next       = 1'b0;
          saturated_next      = 1'b0;
          if (in_data.command == cdds_pkg::CMD_SHIFT) begin
            days_left_next = delta_mag;
            state_next     = cdds_pkg::ST_STEP;
          end else begin
            days_left_next = '0;
            state_next     = cdds_pkg::ST_CHECK;
          end
        end
      end
      cdds_pkg::ST_CHECK: begin
        if (set_ok) begin
          cur_next = set_date;
        end else begin
          cur_next.day   = cdds_pkg::FIRST_DAY;
          cur_next.month = cdds_pkg::JANUARY;
          cur_next.year  = cdds_pkg::DEFAULT_YEAR;
          rejected_next  = 1'b1;
        end
        state_next = cdds_pkg::ST_FINISH;
      end
      cdds_pkg::ST_STEP: begin
        if (days_left == '0) begin
          state_next = cdds_pkg::ST_FINISH;
        end else if (unit_rsp.blocked) begin
          saturated_next = 1'b1;
          days_left_next = '0;
          state_next     = cdds_pkg::ST_FINISH;
        end else begin
          cur_next       = unit_rsp.next;
          days_left_next = days_left - cdds_pkg::DELTA_BITS'(1);
        end
      end
      cdds_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          out_data_next.day             = cur.day;
          out_data_next.month           = cur.month;
          out_data_next.year            = cur.year;
          out_data_next.leap_year       = unit_rsp.leap;
          out_data_next.set_rejected    = rejected;
          out_data_next.range_saturated = saturated;
          out_valid_next                = 1'b1;
          state_next                    = cdds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cdds_pkg::ST_IDLE;
      cur.day   <= cdds_pkg::FIRST_DAY;
      cur.month <= cdds_pkg::JANUARY;
      cur.year  <= cdds_pkg::DEFAULT_YEAR;
      days_left <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      days_left <= days_left_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    set_date  <= set_date_next;
    back      <= back_next;
    rejected  <= rejected_next;
    saturated <= saturated_next;
    out_data  <= out_data_next;
  end

endmodule

// ===== sv/calendar_date_day_stepper_top.sv =====
// Top level of the Gregorian calendar date day stepper.
// Depends on cdds_pkg, cdds_step_unit and cdds_ctrl.

// The block holds one date and answers every command transfer with exactly
// one result transfer. A set command goes through a check state, which checks
// the date against the month length, the month range and the configured
// largest year and rejects year 0, then a finish state that builds the result.
// In a shift command the single shared day step unit moves the date by one
// day per cycle under the sequencer, then the step state sees the count run
// out and the finish state builds the result; a shift that runs into
// 01/01/0000 or 31/12/16383 stops there early with range_saturated set.
// While a command is being worked on, in_stall is high.
// The result register holds a finished result until it is taken, and the next
// command may be transferred meanwhile; its result waits for the register.
module calendar_date_day_stepper_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cdds_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cdds_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [cdds_pkg::YEAR_BITS-1:0] cfg_wdata
);

  // Largest set year; the user must write it only while idle (not enforced).
  logic [cdds_pkg::YEAR_BITS-1:0] max_set_year;

  // The step unit sees the candidate date during the set check and the
  // current date otherwise, so one leap test serves every purpose.
  cdds_pkg::date_t     unit_date;
  logic                unit_back;
  cdds_pkg::step_rsp_t unit_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_set_year <= cdds_pkg::MAX_SET_YEAR_RESET;
    end else if (cfg_we) begin
      max_set_year <= cfg_wdata;
    end
  end

  cdds_step_unit u_step (
    .date (unit_date),
    .back (unit_back),
    .rsp  (unit_rsp)
  );

  cdds_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .max_set_year (max_set_year),
    .unit_date    (unit_date),
    .unit_back    (unit_back),
    .unit_rsp     (unit_rsp)
  );

endmodule

// ===== sv/cdds_checker.sv =====
// Port-level checker for the date stepper, bound to the top level.
// Depends on cdds_pkg and calendar_date_day_stepper_top.
module cdds_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input cdds_pkg::in_item_t             in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input cdds_pkg::out_item_t            out_data,
  input logic                           cfg_we,
  input logic [cdds_pkg::YEAR_BITS-1:0] cfg_wdata
);

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Every result shows a nonzero day and a month from 1 to 12.
  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.day != '0 && out_data.month != '0 &&
                  out_data.month <= cdds_pkg::DECEMBER)
    else $error("result date out of range");

  // A rejected set reports the default date and never saturation.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.set_rejected |->
      out_data.day == cdds_pkg::FIRST_DAY && out_data.month == cdds_pkg::JANUARY &&
      out_data.year == cdds_pkg::DEFAULT_YEAR && !out_data.range_saturated)
    else $error("rejected set with wrong date or flags");

  // An accepted command keeps the block busy in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("command accepted without going busy");

endmodule

bind calendar_date_day_stepper_top cdds_checker u_cdds_checker (.*);
